@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is asserted
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, ignored while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/ssmd_pkg.sv @@
// shared types and constants of the subarray sum multiple detector
package ssmd_pkg;

    localparam int MAX_MODULUS = 1024;
    localparam int RES_W       = $clog2(MAX_MODULUS);
    localparam int MOD_W       = RES_W + 1;
    localparam int VAL_W       = 32;
    localparam int SUM_W       = VAL_W + 1;
    localparam int CNT_W       = $clog2(SUM_W);
    localparam int POS_W       = 16;
    localparam int EPOCH_W     = 8;

    localparam logic [POS_W-1:0]   MAX_LENGTH = 16'hFFFF;
    localparam logic [POS_W-1:0]   MIN_RUN    = 16'd2;
    localparam logic [MOD_W-1:0]   MOD_MAX    = MOD_W'(MAX_MODULUS);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [CNT_W-1:0]   DIV_LAST_STEP = CNT_W'(SUM_W - 1);

    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [MOD_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [RES_W-1:0]   rem;
    } t_div_rsp;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [EPOCH_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic               en;
        logic [RES_W-1:0]   addr;
        t_entry             data;
    } t_tbl_wr;

endpackage

@@ src/ssmd_if.sv @@
// valid/ready channel interfaces for the input and result words
interface ssmd_in_if;
    logic                          valid;
    logic                          ready;
    logic [ssmd_pkg::VAL_W-1:0]    value;
    logic                          last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface ssmd_out_if;
    logic valid;
    logic ready;
    logic found;
    logic done_res;

    modport source (output valid, output found, output done_res, input ready);
    modport sink   (input valid, input found, input done_res, output ready);
endinterface

@@ src/ssmd_divider.sv @@
// bit-serial restoring modulo unit, one dividend bit per cycle
module ssmd_divider (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssmd_pkg::t_div_req   i_req,
    output ssmd_pkg::t_div_rsp   o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [ssmd_pkg::CNT_W-1:0]    r_cnt;
    logic [ssmd_pkg::SUM_W-1:0]    r_sh;
    logic [ssmd_pkg::MOD_W-1:0]    r_div;
    logic [ssmd_pkg::RES_W-1:0]    r_rem;
    logic [ssmd_pkg::MOD_W-1:0]    trial;
    logic [ssmd_pkg::MOD_W-1:0]    n_rem;

    // shift in the next bit, subtract the divisor when it fits
    always_comb begin
        trial = {r_rem, r_sh[ssmd_pkg::SUM_W-1]};
        if (trial >= r_div) begin
            n_rem = trial - r_div;
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ssmd_pkg::DIV_LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sh  <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= {r_sh[ssmd_pkg::SUM_W-2:0], 1'b0};
            r_rem <= n_rem[ssmd_pkg::RES_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

@@ src/ssmd_table.sv @@
// first-position table, one write and one registered read per cycle
module ssmd_table (
    input  logic                         i_clk,
    input  ssmd_pkg::t_tbl_wr            i_wr,
    input  logic [ssmd_pkg::RES_W-1:0]   i_rd_addr,
    output ssmd_pkg::t_entry             o_rd_data
);

    ssmd_pkg::t_entry mem [ssmd_pkg::MAX_MODULUS];
    ssmd_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/subarray_sum_multiple_detector.sv @@
// top level: prefix-sum modulo detector with first-occurrence table
// one word at a time: a new word is taken only after the previous one has updated the table
// steps per word: accept, 33 bit-serial modulo steps, hand-over of the remainder,
// one table read and one update; a stalled result holds the update back
// reset: synchronous active low; afterwards a clearing pass over all 1024 table entries runs,
// and the same pass repeats after every 255th sequence; no word is accepted meanwhile
module subarray_sum_multiple_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ssmd_pkg::MOD_W-1:0]    i_cfg_wdata,
    ssmd_in_if.sink                       i_in,
    ssmd_out_if.source                    o_out
);

    // sequencer states
    localparam logic [2:0] ST_CLR  = 3'd0;   // table clearing pass
    localparam logic [2:0] ST_IDLE = 3'd1;   // waiting for an input word
    localparam logic [2:0] ST_DIV  = 3'd2;   // modulo unit running
    localparam logic [2:0] ST_RD   = 3'd3;   // table read in flight
    localparam logic [2:0] ST_UPD  = 3'd4;   // compare, update table, load result

    logic [2:0]                        r_state;
    logic [2:0]                        n_state;

    // configuration
    logic [ssmd_pkg::MOD_W-1:0]        r_modulus;
    logic [ssmd_pkg::MOD_W-1:0]        eff_mod;

    // sequence state
    logic [ssmd_pkg::RES_W-1:0]        r_res;       // running residue
    logic [ssmd_pkg::POS_W-1:0]        r_pos;       // current prefix position
    logic                              r_found;     // sticky found flag
    logic                              r_last;      // last flag of the word in flight
    logic [ssmd_pkg::EPOCH_W-1:0]      r_epoch;     // tag that marks entries of this sequence
    logic [ssmd_pkg::RES_W-1:0]        r_clr_addr;

    // output register
    logic                              r_out_valid;
    logic                              r_out_found;
    logic                              r_out_done;

    ssmd_pkg::t_div_req                div_req;
    ssmd_pkg::t_div_rsp                div_rsp;
    ssmd_pkg::t_tbl_wr                 tbl_wr;
    ssmd_pkg::t_entry                  tbl_rd;

    logic                              in_acc;
    logic                              out_free;
    logic                              upd_go;
    logic                              seen;
    logic [ssmd_pkg::POS_W-1:0]        first_pos;
    logic                              hit;
    logic                              found_now;

    // a modulus of zero acts as one, anything above the table size saturates
    always_comb begin
        if (r_modulus == '0) begin
            eff_mod = ssmd_pkg::MOD_W'(1);
        end else if (r_modulus > ssmd_pkg::MOD_MAX) begin
            eff_mod = ssmd_pkg::MOD_MAX;
        end else begin
            eff_mod = r_modulus;
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign upd_go     = (r_state == ST_UPD) && out_free;

    // reduce (residue + value) by the modulus in one pass
    assign div_req.start    = in_acc;
    assign div_req.dividend = {{(ssmd_pkg::SUM_W-ssmd_pkg::RES_W){1'b0}}, r_res}
                              + {1'b0, i_in.value};
    assign div_req.divisor  = eff_mod;

    ssmd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // residue zero is always seen at position zero; other entries count
    // only when their tag matches the current sequence
    always_comb begin
        if (r_res == '0) begin
            seen      = 1'b1;
            first_pos = '0;
        end else begin
            seen      = (tbl_rd.tag == r_epoch);
            first_pos = tbl_rd.pos;
        end
        hit       = seen && (r_pos >= first_pos) && ((r_pos - first_pos) >= ssmd_pkg::MIN_RUN);
        found_now = r_found || hit;
    end

    // table write: clearing pass or first occurrence of a residue
    always_comb begin
        if (r_state == ST_CLR) begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = r_clr_addr;
            tbl_wr.data = '0;
        end else begin
            tbl_wr.en       = upd_go && !seen;
            tbl_wr.addr     = r_res;
            tbl_wr.data.pos = r_pos;
            tbl_wr.data.tag = r_epoch;
        end
    end

    ssmd_table u_tbl (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (r_res),
        .o_rd_data (tbl_rd)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (upd_go) begin
                    // tags run out: wipe the table before the next sequence
                    if (r_last && (r_epoch == ssmd_pkg::EPOCH_LAST)) begin
                        n_state = ST_CLR;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_modulus   <= ssmd_pkg::MOD_W'(1);
            r_res       <= '0;
            r_pos       <= '0;
            r_found     <= 1'b0;
            r_last      <= 1'b0;
            r_epoch     <= ssmd_pkg::EPOCH_FIRST;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end

            if (r_state == ST_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end

            if (in_acc) begin
                r_last <= i_in.last;
                // position saturates at the longest supported sequence
                if (r_pos != ssmd_pkg::MAX_LENGTH) begin
                    r_pos <= r_pos + 1'b1;
                end
            end

            if ((r_state == ST_DIV) && div_rsp.done) begin
                r_res <= div_rsp.rem;
            end

            // a new result replaces the one leaving in the same cycle
            if (upd_go) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_res   <= '0;
                    r_pos   <= '0;
                    r_found <= 1'b0;
                    if (r_epoch == ssmd_pkg::EPOCH_LAST) begin
                        r_epoch <= ssmd_pkg::EPOCH_FIRST;
                    end else begin
                        r_epoch <= r_epoch + 1'b1;
                    end
                end else begin
                    r_found <= found_now;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_out_found <= found_now;
            r_out_done  <= r_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.found    = r_out_found;
    assign o_out.done_res = r_out_done;

endmodule

@@ src/ssmd_checker.sv @@
// port-level checks of the detector, bound to the top level
`include "assert_macros.svh"

module ssmd_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  logic i_out_found,
    input  logic i_out_done
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    // one word at a time: busy right after an accept
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !i_in_ready)
    // clearing pass holds off input right after reset
    `ASSERT_IMPL(a_clear_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !i_in_ready)
    // stalled result stays put
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(i_out_found) && $stable(i_out_done))

endmodule

bind subarray_sum_multiple_detector ssmd_checker u_ssmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_found (o_out.found),
    .i_out_done  (o_out.done_res)
);
